// File: rtl/integral_augmented_state_observer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integral-augmented state observer
// Concurrent checks that expand to nothing in a synthesis build.
// ----------------------------------------------------------------------------
`ifndef INTEGRAL_AUGMENTED_STATE_OBSERVER_ASSERT_SVH
`define INTEGRAL_AUGMENTED_STATE_OBSERVER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent is checked in the same cycle as the antecedent.
`define IASO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define IASO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`else

`define IASO_ASSERT_NOW(label, ante, cons, msg)

`define IASO_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/iaso_pkg.sv
// ----------------------------------------------------------------------------
// Observer package
// Fixed-point types, word layouts and saturating helpers shared by the block.
// ----------------------------------------------------------------------------
package iaso_pkg;

    // Signed Q16.16 value, raw product and widened sum.
    typedef logic signed [31:0] q_t;
    typedef logic signed [63:0] prod_t;
    typedef logic signed [33:0] acc_t;

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;

    // Sample period in Q16.16.
    localparam q_t PERIOD_Q16 = 32'sd1311;

    // Eight 32-bit registers at byte addresses 0 to 28.
    localparam int CFG_ADDR_W = 5;

    typedef struct packed {
        q_t m00;
        q_t m01;
        q_t m10;
        q_t m11;
        q_t g0;
        q_t g1;
        q_t k0;
        q_t k1;
    } cfg_t;

    typedef struct packed {
        q_t   observation;
        q_t   setpoint;
        q_t   control_input;
        logic ball_absent;
        logic actuator_saturated;
    } sample_t;

    typedef struct packed {
        q_t tracking_error;
        q_t position_estimate;
        q_t velocity_estimate;
        q_t error_integral;
        q_t applied_control;
    } result_t;

    // Work handed from the front part to the state update.
    typedef struct packed {
        q_t   err;
        q_t   control;
        acc_t base0;
        acc_t base1;
        q_t   int_step;
        logic absent;
        logic saturated;
    } cmd_t;

    // Clamp a widened sum to the 32-bit signed range.
    function automatic q_t sat_acc(input acc_t v);
        q_t r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
        begin
            r = v[31:0];
        end
        else if (v[33])
        begin
            r = Q_MIN;
        end
        else
        begin
            r = Q_MAX;
        end
        return r;
    endfunction

    // Q16.16 product: arithmetic shift by 16 (floor), then clamp.
    function automatic q_t qmul(input prod_t p);
        q_t r;
        if (p[63:47] == 17'h00000 || p[63:47] == 17'h1FFFF)
        begin
            r = p[47:16];
        end
        else if (p[63])
        begin
            r = Q_MIN;
        end
        else
        begin
            r = Q_MAX;
        end
        return r;
    endfunction

endpackage

// File: rtl/iaso_stream_if.sv
// ----------------------------------------------------------------------------
// Observer stream interface
// Valid/ready channel carrying one word of the given payload type.
// ----------------------------------------------------------------------------
interface iaso_stream_if #(
    parameter type PAYLOAD_T = logic
) ();

    logic     valid;
    logic     ready;
    PAYLOAD_T payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// File: rtl/integral_augmented_state_observer.sv
// Path: an accepted sample word is registered in stage A and stage B, written
// into the queue, taken into the update part's product registers and then
// loaded into the output register, which offers its result word.
// Rate: the state loop (matrix multiply, then sum and clamp) takes a new word
// only once it is through with the last; from idle the input takes a burst of
// 2 * QUEUE_DEPTH + 1 words back to back. Reset (rst_n low) clears gains and states.
// ----------------------------------------------------------------------------
// Integral-augmented state observer
// Luenberger observer on position and velocity with an anti-windup error
// integral, in Q16.16 fixed point, with an APB-style register port.
// ----------------------------------------------------------------------------
`include "integral_augmented_state_observer_assert.svh"

module integral_augmented_state_observer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [iaso_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    iaso_stream_if.sink                     sample,
    iaso_stream_if.source                   result
);
    import iaso_pkg::*;

    // The design is split where the dependence on stored state begins.
    // Everything that depends only on the incoming word (the clamped tracking
    // error, the input and correction products and the integral increment)
    // is worked out in the front part, which runs one word per cycle while the
    // queue has room. Its commands wait in a short queue, so a burst of samples
    // is taken without stalling even though the update part is slower.
    //
    // The update part must see the previous word's estimates before it can
    // multiply them by the observer matrix, so it works on one word at a
    // time: it first registers the four matrix products, then clamps them,
    // adds the queued terms, updates the states and loads the output register.
    // The output register lets the sink stall without holding up the front part.

    cfg_t cfg;
    logic upd_take;

    iaso_stream_if #(.PAYLOAD_T(cmd_t)) q_push ();
    iaso_stream_if #(.PAYLOAD_T(cmd_t)) q_pop ();

    iaso_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    iaso_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .sample (sample),
        .cmd    (q_push)
    );

    iaso_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (q_pop)
    );

    iaso_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cmd    (q_pop),
        .result (result)
    );

    // A command moves from the queue into the update part.
    assign upd_take = q_pop.valid && q_pop.ready;

    // The update part takes a command only when it is idle, so it is busy in
    // the cycle after any take.
    `IASO_ASSERT_NEXT(a_take_then_busy, upd_take, !q_pop.ready, "two takes in a row")

    // Once a take could have reached the output register, a result word is on
    // offer, either the new one or an earlier one still waiting for the sink.
    `IASO_ASSERT_NOW(a_take_gives_word, upd_take, ##2 result.valid, "no result word after a take")

    // While busy, the update part either finishes or is held by a waiting word.
    `IASO_ASSERT_NEXT(a_busy_progress, !q_pop.ready, q_pop.ready || result.valid, "update stalled")

endmodule

// File: rtl/iaso_cfg_regs.sv
// ----------------------------------------------------------------------------
// Observer configuration registers
// APB-style register file holding the observer, input and correction gains.
// ----------------------------------------------------------------------------
module iaso_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iaso_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output iaso_pkg::cfg_t                 cfg
);
    import iaso_pkg::*;

    typedef enum logic [2:0] {
        REG_M00 = 3'd0,
        REG_M01 = 3'd1,
        REG_M10 = 3'd2,
        REG_M11 = 3'd3,
        REG_G0  = 3'd4,
        REG_G1  = 3'd5,
        REG_K0  = 3'd6,
        REG_K1  = 3'd7
    } reg_idx_t;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_M00: cfg_next.m00 = pwdata;
                REG_M01: cfg_next.m01 = pwdata;
                REG_M10: cfg_next.m10 = pwdata;
                REG_M11: cfg_next.m11 = pwdata;
                REG_G0:  cfg_next.g0  = pwdata;
                REG_G1:  cfg_next.g1  = pwdata;
                REG_K0:  cfg_next.k0  = pwdata;
                REG_K1:  cfg_next.k1  = pwdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_M00: prdata = cfg_reg.m00;
            REG_M01: prdata = cfg_reg.m01;
            REG_M10: prdata = cfg_reg.m10;
            REG_M11: prdata = cfg_reg.m11;
            REG_G0:  prdata = cfg_reg.g0;
            REG_G1:  prdata = cfg_reg.g1;
            REG_K0:  prdata = cfg_reg.k0;
            REG_K1:  prdata = cfg_reg.k1;
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/iaso_front.sv
// ----------------------------------------------------------------------------
// Observer front part
// Takes sample words, forms the tracking error and all products that do not
// depend on the stored estimates, and hands the result on as a command.
// ----------------------------------------------------------------------------
module iaso_front (
    input  logic            clk,
    input  logic            rst_n,
    input  iaso_pkg::cfg_t  cfg,
    iaso_stream_if.sink     sample,
    iaso_stream_if.source   cmd
);
    import iaso_pkg::*;

    // Stage A: error and captured inputs.
    logic  a_valid_reg;
    logic  a_valid_next;
    q_t    a_err_reg;
    q_t    a_ctrl_reg;
    logic  a_absent_reg;
    logic  a_sat_reg;

    // Stage B: registered products.
    logic  b_valid_reg;
    logic  b_valid_next;
    prod_t b_pg0_reg;
    prod_t b_pg1_reg;
    prod_t b_pk0_reg;
    prod_t b_pk1_reg;
    prod_t b_pi_reg;
    q_t    b_err_reg;
    q_t    b_ctrl_reg;
    logic  b_absent_reg;
    logic  b_sat_reg;

    logic  a_ready;
    logic  b_ready;
    q_t    err_in;
    cmd_t  cmd_word;

    assign b_ready      = !b_valid_reg || cmd.ready;
    assign a_ready      = !a_valid_reg || b_ready;
    assign sample.ready = a_ready;

    assign err_in = sat_acc(acc_t'(sample.payload.observation)
                            - acc_t'(sample.payload.setpoint));

    assign a_valid_next = a_ready ? sample.valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && a_ready)
        begin
            a_err_reg    <= err_in;
            a_ctrl_reg   <= sample.payload.control_input;
            a_absent_reg <= sample.payload.ball_absent;
            a_sat_reg    <= sample.payload.actuator_saturated;
        end
        if (a_valid_reg && b_ready)
        begin
            b_pg0_reg    <= cfg.g0 * a_ctrl_reg;
            b_pg1_reg    <= cfg.g1 * a_ctrl_reg;
            b_pk0_reg    <= cfg.k0 * a_err_reg;
            b_pk1_reg    <= cfg.k1 * a_err_reg;
            b_pi_reg     <= a_err_reg * PERIOD_Q16;
            b_err_reg    <= a_err_reg;
            b_ctrl_reg   <= a_ctrl_reg;
            b_absent_reg <= a_absent_reg;
            b_sat_reg    <= a_sat_reg;
        end
    end

    // Input and correction terms are each clamped before they are summed.
    always_comb
    begin
        cmd_word.err       = b_err_reg;
        cmd_word.control   = b_ctrl_reg;
        cmd_word.base0     = acc_t'(qmul(b_pg0_reg)) + acc_t'(qmul(b_pk0_reg));
        cmd_word.base1     = acc_t'(qmul(b_pg1_reg)) + acc_t'(qmul(b_pk1_reg));
        cmd_word.int_step  = qmul(b_pi_reg);
        cmd_word.absent    = b_absent_reg;
        cmd_word.saturated = b_sat_reg;
    end

    assign cmd.valid   = b_valid_reg;
    assign cmd.payload = cmd_word;

endmodule

// File: rtl/iaso_queue.sv
// ----------------------------------------------------------------------------
// Observer command queue
// Short first-in first-out buffer between the front part and the update.
// ----------------------------------------------------------------------------
module iaso_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    iaso_stream_if.sink   push,
    iaso_stream_if.source pop
);
    import iaso_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push_fire;
    logic             pop_fire;

    assign push.ready  = count_reg != CNT_W'(DEPTH);
    assign pop.valid   = count_reg != '0;
    assign pop.payload = mem_reg[rd_ptr_reg];

    assign push_fire = push.valid && push.ready;
    assign pop_fire  = pop.valid && pop.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push.payload;
        end
    end

endmodule

// File: rtl/iaso_back.sv
// ----------------------------------------------------------------------------
// Observer state update
// Multiplies the stored estimates by the observer matrix, adds the queued
// terms, updates the four states and holds the result word for the sink.
// ----------------------------------------------------------------------------
module iaso_back (
    input  logic            clk,
    input  logic            rst_n,
    input  iaso_pkg::cfg_t  cfg,
    iaso_stream_if.sink     cmd,
    iaso_stream_if.source   result
);
    import iaso_pkg::*;

    logic    busy_reg;
    logic    busy_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    cmd_t    cur_reg;
    prod_t   mp00_reg;
    prod_t   mp01_reg;
    prod_t   mp10_reg;
    prod_t   mp11_reg;
    q_t      pos_reg;
    q_t      vel_reg;
    q_t      int_reg;
    q_t      ctl_reg;
    result_t out_reg;

    logic    take;
    logic    finish;
    q_t      pos_new;
    q_t      vel_new;
    q_t      int_new;
    q_t      ctl_new;

    assign cmd.ready = !busy_reg;
    assign take      = cmd.valid && !busy_reg;
    assign finish    = busy_reg && (!out_valid_reg || result.ready);

    always_comb
    begin
        busy_next = busy_reg;
        if (take)
        begin
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        if (cur_reg.absent)
        begin
            pos_new = '0;
            vel_new = '0;
            int_new = '0;
            ctl_new = '0;
        end
        else
        begin
            pos_new = sat_acc(acc_t'(qmul(mp00_reg)) + acc_t'(qmul(mp01_reg))
                              + cur_reg.base0);
            vel_new = sat_acc(acc_t'(qmul(mp10_reg)) + acc_t'(qmul(mp11_reg))
                              + cur_reg.base1);
            int_new = cur_reg.saturated ? int_reg
                    : sat_acc(acc_t'(int_reg) + acc_t'(cur_reg.int_step));
            ctl_new = cur_reg.control;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            int_reg       <= '0;
            ctl_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                pos_reg <= pos_new;
                vel_reg <= vel_new;
                int_reg <= int_new;
                ctl_reg <= ctl_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg  <= cmd.payload;
            mp00_reg <= cfg.m00 * pos_reg;
            mp01_reg <= cfg.m01 * vel_reg;
            mp10_reg <= cfg.m10 * pos_reg;
            mp11_reg <= cfg.m11 * vel_reg;
        end
        if (finish)
        begin
            out_reg.tracking_error    <= cur_reg.err;
            out_reg.position_estimate <= pos_new;
            out_reg.velocity_estimate <= vel_new;
            out_reg.error_integral    <= int_new;
            out_reg.applied_control   <= ctl_new;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Observer testbench
// Drives sample words and gain writes into the integral-augmented state
// observer, keeps its own fixed-point copy of the estimates and checks every
// result word field by field, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb;

    import iaso_pkg::*;

    // Gain registers in the order of the register map; each sits at byte address 4*index.
    localparam int REG_COUNT = 8;
    typedef enum int {
        R_M00 = 0,
        R_M01 = 1,
        R_M10 = 2,
        R_M11 = 3,
        R_G0  = 4,
        R_G1  = 5,
        R_K0  = 6,
        R_K1  = 7
    } gain_reg_e;

    // The limit leaves a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT   = 300000;
    // Quiet cycles after the last result word, leaving the block fully idle.
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASES        = 10;
    localparam int PHASE_WORDS   = 65;

    // ------------------------------------------------------------------------
    // Expected-result ledger: a private copy of the gains and of the four
    // stored estimates, advanced once for every accepted sample word.
    // ------------------------------------------------------------------------
    class estimate_ledger;
        q_t      gains [REG_COUNT];
        q_t      position;
        q_t      velocity;
        q_t      integral;
        q_t      control;
        result_t expected_words [$];
        int      fault_count;

        function new();
            foreach (gains[i])
            begin
                gains[i] = '0;
            end
            position    = '0;
            velocity    = '0;
            integral    = '0;
            control     = '0;
            fault_count = 0;
        endfunction

        static function q_t clamp32(longint v);
            if (v > longint'(Q_MAX))
            begin
                return Q_MAX;
            end
            if (v < longint'(Q_MIN))
            begin
                return Q_MIN;
            end
            return q_t'(v);
        endfunction

        // Exact product, arithmetic shift (floor) by 16, then clamp.
        static function q_t fx_mul(q_t a, q_t b);
            longint prod;
            prod = longint'(a) * longint'(b);
            return clamp32(prod >>> 16);
        endfunction

        function result_t advance_estimates(sample_t s);
            result_t r;
            longint  pos_sum;
            longint  vel_sum;
            q_t      err;
            err = clamp32(longint'(s.observation) - longint'(s.setpoint));
            if (s.ball_absent)
            begin
                position = '0;
                velocity = '0;
                integral = '0;
                control  = '0;
            end
            else
            begin
                // Both rows use the old states, so form both sums first.
                pos_sum = longint'(fx_mul(gains[R_M00], position))
                        + longint'(fx_mul(gains[R_M01], velocity))
                        + longint'(fx_mul(gains[R_G0], s.control_input))
                        + longint'(fx_mul(gains[R_K0], err));
                vel_sum = longint'(fx_mul(gains[R_M10], position))
                        + longint'(fx_mul(gains[R_M11], velocity))
                        + longint'(fx_mul(gains[R_G1], s.control_input))
                        + longint'(fx_mul(gains[R_K1], err));
                position = clamp32(pos_sum);
                velocity = clamp32(vel_sum);
                if (!s.actuator_saturated)
                begin
                    integral = clamp32(longint'(integral)
                                       + longint'(fx_mul(err, PERIOD_Q16)));
                end
                control = s.control_input;
            end
            r.tracking_error    = err;
            r.position_estimate = position;
            r.velocity_estimate = velocity;
            r.error_integral    = integral;
            r.applied_control   = control;
            return r;
        endfunction

        function void note_sample(sample_t s);
            expected_words.push_back(advance_estimates(s));
        endfunction

        function void compare(string field, q_t want, q_t got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                fault_count++;
            end
        endfunction

        function void check_result(result_t r);
            result_t want;
            if (expected_words.size() == 0)
            begin
                $error("result word arrived with nothing expected");
                fault_count++;
                return;
            end
            want = expected_words.pop_front();
            compare("tracking_error", want.tracking_error, r.tracking_error);
            compare("position_estimate", want.position_estimate, r.position_estimate);
            compare("velocity_estimate", want.velocity_estimate, r.velocity_estimate);
            compare("error_integral", want.error_integral, r.error_integral);
            compare("applied_control", want.applied_control, r.applied_control);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, register port and the two stream channels.
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    iaso_stream_if #(.PAYLOAD_T(sample_t)) sample_ch ();
    iaso_stream_if #(.PAYLOAD_T(result_t)) result_ch ();

    integral_augmented_state_observer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch),
        .result  (result_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    estimate_ledger ledger;
    // While set, neither side inserts idle cycles, so the block runs flat out.
    bit             steady;
    int unsigned    cycle_count;
    q_t             next_gains [REG_COUNT];

    // ------------------------------------------------------------------------
    // Value generation. Modest values keep the estimates inside their range
    // for long stretches; the rest also hit the rails, zero and random bit patterns.
    // ------------------------------------------------------------------------
    function automatic q_t pick_value(bit modest);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (modest && roll < 8)
        begin
            return q_t'($urandom_range(0, 524288)) - q_t'(262144);
        end
        case (roll)
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3, 4:    return q_t'($urandom_range(0, 524288)) - q_t'(262144);
            default: return q_t'($urandom);
        endcase
    endfunction

    function automatic sample_t make_sample(q_t obs, q_t sp, q_t u, logic absent,
                                            logic held);
        sample_t s;
        s.observation        = obs;
        s.setpoint           = sp;
        s.control_input      = u;
        s.ball_absent        = absent;
        s.actuator_saturated = held;
        return s;
    endfunction

    // A lost ball is rare so that the estimates get many steps to evolve.
    function automatic sample_t random_sample(bit modest);
        return make_sample(pick_value(modest), pick_value(modest), pick_value(modest),
                           $urandom_range(0, 15) == 0, $urandom_range(0, 3) == 0);
    endfunction

    // A well-behaved observer: near-identity dynamics with small gains.
    function automatic void stable_gains();
        next_gains[R_M00] = 32'sh0001_0000;
        next_gains[R_M01] = PERIOD_Q16;
        next_gains[R_M10] = -32'sh0000_07D0;
        next_gains[R_M11] = 32'sh0000_FA00;
        next_gains[R_G0]  = 32'sh0000_0064;
        next_gains[R_G1]  = PERIOD_Q16;
        next_gains[R_K0]  = 32'sh0000_7530;
        next_gains[R_K1]  = 32'sh0000_1388;
    endfunction

    // ------------------------------------------------------------------------
    // Register port. A transfer is a setup phase then an access phase; psel goes
    // low again after it, so that psel never falls and rises in one step.
    // ------------------------------------------------------------------------
    task automatic apb_write(int idx, q_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        ledger.gains[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(int idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_ADDR_W'(idx * 4);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Writes every gain register from next_gains and reads each one back.
    task automatic program_gains();
        logic [31:0] readback;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            apb_write(i, next_gains[i]);
            apb_read(i, readback);
            ledger.compare($sformatf("register %0d readback", i), next_gains[i],
                           q_t'(readback));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sample side. valid stays high from one word to the next when no gap is
    // drawn; the ledger is advanced at the edge that accepts the word.
    // ------------------------------------------------------------------------
    task automatic send_sample(sample_t s);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.payload <= s;
        sample_ch.valid   <= 1'b1;
        do @(posedge clk); while (sample_ch.ready !== 1'b1);
        ledger.note_sample(s);
    endtask

    // Lets every outstanding result word arrive, then leaves the block quiet so
    // that a register write finds it idle.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (ledger.expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Rail values on every field, a lost ball with the saturation flag also
    // set, a frozen integral and an error of one unit from half-unit inputs.
    task automatic run_extremes();
        send_sample(make_sample(Q_MAX, Q_MIN, Q_MAX, 1'b0, 1'b0));
        send_sample(make_sample(Q_MIN, Q_MAX, Q_MIN, 1'b0, 1'b0));
        send_sample(make_sample(Q_MAX, Q_MAX, 32'sh0001_0000, 1'b0, 1'b1));
        send_sample(make_sample('0, '0, '0, 1'b0, 1'b0));
        send_sample(make_sample(Q_MIN, '0, -32'sd1, 1'b1, 1'b1));
        send_sample(make_sample(32'sh0000_8000, 32'shFFFF_8000, Q_MAX, 1'b0, 1'b0));
    endtask

    // ------------------------------------------------------------------------
    // Result side: an independent stall is drawn for every word.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 12);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
            ledger.check_result(result_ch.payload);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: directed words under zero, all-maximum, all-minimum and
    // well-behaved gains, then random phases, each with fresh gains.
    // ------------------------------------------------------------------------
    initial
    begin
        sample_t s;
        bit      pos_first;
        int      kind;
        ledger  = new();
        steady  = 1'b0;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        sample_ch.valid   <= 1'b0;
        sample_ch.payload <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Gains are zero out of reset, so only the error, integral and applied control move.
        send_sample(make_sample(32'sh0002_0000, 32'sh0001_0000, 32'sh0000_4000,
                                1'b0, 1'b0));
        send_sample(make_sample(Q_MAX, Q_MIN, Q_MIN, 1'b0, 1'b0));
        drain();

        // With every gain at a rail, products and state sums of rail-sized inputs clamp at one rail or the other.
        foreach (next_gains[i])
        begin
            next_gains[i] = Q_MAX;
        end
        program_gains();
        run_extremes();
        drain();
        foreach (next_gains[i])
        begin
            next_gains[i] = Q_MIN;
        end
        program_gains();
        run_extremes();
        drain();

        // Integral builds up, freezes while the actuator is saturated, takes
        // a tiny error on either side (floor rounding), then the ball is lost
        // and the observer restarts from zero.
        stable_gains();
        program_gains();
        send_sample(make_sample(32'sh0001_0000, '0, 32'sh0000_8000, 1'b0, 1'b0));
        send_sample(make_sample(32'sh0001_0000, '0, 32'sh0000_8000, 1'b0, 1'b0));
        send_sample(make_sample(32'sh0003_0000, 32'sh0001_0000, -32'sh0001_0000,
                                1'b0, 1'b1));
        send_sample(make_sample('0, 32'sh0002_0000, '0, 1'b0, 1'b0));
        send_sample(make_sample(32'sd1, '0, 32'sd1, 1'b0, 1'b0));
        send_sample(make_sample('0, 32'sd1, -32'sd1, 1'b0, 1'b0));
        send_sample(make_sample(32'sh0001_0000, '0, Q_MAX, 1'b1, 1'b0));
        send_sample(make_sample(32'sh0001_0000, '0, 32'sh0000_4000, 1'b0, 1'b0));
        drain();

        // Random phases. Kinds: well-behaved gains, random gains, gains at the
        // rails or at unity, integral wind-up against both rails, random gains
        // with modest samples.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            kind = ph % 5;
            case (kind)
                0, 3:
                begin
                    stable_gains();
                end
                2:
                begin
                    foreach (next_gains[i])
                    begin
                        case ($urandom_range(0, 4))
                            0:       next_gains[i] = Q_MAX;
                            1:       next_gains[i] = Q_MIN;
                            2:       next_gains[i] = '0;
                            3:       next_gains[i] = 32'sh0001_0000;
                            default: next_gains[i] = -32'sh0001_0000;
                        endcase
                    end
                end
                default:
                begin
                    foreach (next_gains[i])
                    begin
                        next_gains[i] = pick_value(1'b0);
                    end
                end
            endcase
            program_gains();
            pos_first = (ph < PHASES / 2);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if (k % 20 == 0)
                begin
                    steady = ($urandom_range(0, 3) == 0);
                end
                if (kind == 3)
                begin
                    // About fifty unfrozen steps of full-scale error reach the
                    // integral's rail; the sign flips near the end of the phase.
                    if ((k < 60) == pos_first)
                    begin
                        s = make_sample(Q_MAX - q_t'($urandom_range(0, 65535)),
                                        Q_MIN + q_t'($urandom_range(0, 65535)),
                                        pick_value(1'b1), 1'b0,
                                        $urandom_range(0, 15) == 0);
                    end
                    else
                    begin
                        s = make_sample(Q_MIN + q_t'($urandom_range(0, 65535)),
                                        Q_MAX - q_t'($urandom_range(0, 65535)),
                                        pick_value(1'b1), 1'b0,
                                        $urandom_range(0, 15) == 0);
                    end
                end
                else
                begin
                    s = random_sample(kind == 0 || kind == 4);
                end
                send_sample(s);
            end
            steady = 1'b0;
            drain();
        end

        if (ledger.fault_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
